[hdl/ldb_pkg.sv]
// Package for the LED dimmer and blinker: command codes, register indexes,
// the result record and the percent-to-duty conversion.
// No dependencies.
`timescale 1ns / 1ps

package ldb_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    localparam logic [1:0] REG_ON_TIME     = 2'd0;
    localparam logic [1:0] REG_OFF_TIME    = 2'd1;
    localparam logic [1:0] REG_FLASH_TOTAL = 2'd2;

    localparam logic [6:0]  PCT_MAX      = 7'd100;
    localparam logic [6:0]  PCT_MIN_LIT  = 7'd1;
    localparam logic [15:0] TIME_RESET   = 16'd500;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
    // 5243 / 2^19 approximates 1/100; exact floor for products up to 25500
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_SHIFT  = 19;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic [6:0] steady_level;
        logic       blink_active;
        logic       phase_lit;
        logic [7:0] flashes_left;
        logic       lamp_on;
    } result_t;

    // pct*255/100, truncated; the divide is a multiply by a reciprocal
    function automatic logic [7:0] duty_of(input logic [6:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        begin
            scaled = ({8'd0, pct} << 8) - {8'd0, pct};
            prod   = {13'd0, scaled} * {15'd0, RECIP_100};
            duty_of = prod[RECIP_SHIFT +: 8];
        end
    endfunction

endpackage

[hdl/ldb_engine.sv]
// Command engine: configuration registers, written through cfg_we, and run
// settings and blink state, updated once per accepted beat; also forms the result record.
// Depends on ldb_pkg.
`timescale 1ns / 1ps

module ldb_engine
    import ldb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        take,
    input  logic [1:0]  mode,
    input  logic [7:0]  level,
    output result_t     result
);

    logic [15:0] on_time_reg, off_time_reg;
    logic [7:0]  flash_total_reg;
    logic [15:0] run_on_reg, run_on_next;
    logic [15:0] run_off_reg, run_off_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic [6:0]  steady_reg, steady_next;
    logic [6:0]  saved_reg, saved_next;
    logic [6:0]  flash_reg, flash_next;
    logic        running_reg, running_next;
    logic        lit_reg, lit_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic [6:0]  lvl_set, lvl_start, duty_pct;
    logic [15:0] span, elapsed_inc;
    logic [7:0]  rem_dec;
    mode_t       cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg     <= TIME_RESET;
            off_time_reg    <= TIME_RESET;
            flash_total_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ON_TIME:     on_time_reg     <= cfg_data;
                REG_OFF_TIME:    off_time_reg    <= cfg_data;
                REG_FLASH_TOTAL: flash_total_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cmd       = mode_t'(mode);
        lvl_set   = (level > {1'b0, PCT_MAX}) ? PCT_MAX : level[6:0];
        lvl_start = (level == 8'd0) ? PCT_MIN_LIT : lvl_set;

        span        = lit_reg ? run_on_reg : run_off_reg;
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
        rem_dec     = (run_count_reg != 8'd0 && remaining_reg != 8'd0)
                      ? remaining_reg - 8'd1 : remaining_reg;

        run_on_next    = run_on_reg;
        run_off_next   = run_off_reg;
        run_count_next = run_count_reg;
        steady_next    = steady_reg;
        saved_next     = saved_reg;
        flash_next     = flash_reg;
        running_next   = running_reg;
        lit_next       = lit_reg;
        remaining_next = remaining_reg;
        elapsed_next   = elapsed_reg;

        case (cmd)
            MODE_SET:
            begin
                running_next = 1'b0;
                lit_next     = 1'b0;
                steady_next  = lvl_set;
            end
            MODE_START:
            begin
                if (!running_reg)
                    saved_next = steady_reg;
                flash_next     = lvl_start;
                run_on_next    = on_time_reg;
                run_off_next   = off_time_reg;
                run_count_next = flash_total_reg;
                remaining_next = flash_total_reg;
                running_next   = 1'b1;
                lit_next       = 1'b1;
                elapsed_next   = 16'd0;
            end
            MODE_STOP:
            begin
                if (running_reg)
                begin
                    running_next = 1'b0;
                    lit_next     = 1'b0;
                    steady_next  = saved_reg;
                end
            end
            MODE_TICK:
            begin
                if (running_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= span)
                    begin
                        elapsed_next = 16'd0;
                        if (lit_reg)
                        begin
                            lit_next       = 1'b0;
                            remaining_next = rem_dec;
                            // counted run finished: restore the saved level
                            if (run_count_reg != 8'd0 && rem_dec == 8'd0)
                            begin
                                running_next = 1'b0;
                                steady_next  = saved_reg;
                            end
                        end
                        else
                        begin
                            lit_next = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (running_next)
            duty_pct = lit_next ? flash_next : 7'd0;
        else
            duty_pct = steady_next;

        result.pwm_duty     = duty_of(duty_pct);
        result.steady_level = steady_next;
        result.blink_active = running_next;
        result.phase_lit    = lit_next;
        result.flashes_left = remaining_next;
        result.lamp_on      = running_next ? lit_next : (steady_next != 7'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_on_reg    <= TIME_RESET;
            run_off_reg   <= TIME_RESET;
            run_count_reg <= 8'd0;
            steady_reg    <= 7'd0;
            saved_reg     <= 7'd0;
            flash_reg     <= PCT_MAX;
            running_reg   <= 1'b0;
            lit_reg       <= 1'b0;
            remaining_reg <= 8'd0;
            elapsed_reg   <= 16'd0;
        end
        else if (take)
        begin
            run_on_reg    <= run_on_next;
            run_off_reg   <= run_off_next;
            run_count_reg <= run_count_next;
            steady_reg    <= steady_next;
            saved_reg     <= saved_next;
            flash_reg     <= flash_next;
            running_reg   <= running_next;
            lit_reg       <= lit_next;
            remaining_reg <= remaining_next;
            elapsed_reg   <= elapsed_next;
        end
    end

endmodule

[hdl/ldb_out.sv]
// Output register: holds one result beat until the consumer takes it and
// lets a new beat in whenever the slot is free or being emptied.
// Depends on ldb_pkg.
`timescale 1ns / 1ps

module ldb_out
    import ldb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    slot_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t held
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

[hdl/led_dimmer_blinker_core.sv]
// LED dimmer and blinker core.
// The result of a beat is registered and valid in the cycle after it is accepted.
// Throughput: one beat per cycle; input ready drops only while a result
// waits and the consumer holds out_ready low.
// Reset (rst_n, asynchronous): LED dark, no run, blink level 100,
// on and off times 500 ms, endless flash count.
`timescale 1ns / 1ps

module led_dimmer_blinker_core
    import ldb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pwm_duty,
    output logic [6:0]  steady_level,
    output logic        blink_active,
    output logic        phase_lit,
    output logic [7:0]  flashes_left,
    output logic        lamp_on
);

    logic    take;
    result_t fresh, held;

    assign take = in_valid && in_ready;

    ldb_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .take     (take),
        .mode     (mode),
        .level    (level),
        .result   (fresh)
    );

    ldb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (fresh),
        .slot_free (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign pwm_duty     = held.pwm_duty;
    assign steady_level = held.steady_level;
    assign blink_active = held.blink_active;
    assign phase_lit    = held.phase_lit;
    assign flashes_left = held.flashes_left;
    assign lamp_on      = held.lamp_on;

endmodule
